/* design/spatial_audio_gain_pan_unit_defines.svh */
// assertion macros used by the back end (sagp_back)
`ifndef SPATIAL_AUDIO_GAIN_PAN_UNIT_DEFINES_SVH
`define SPATIAL_AUDIO_GAIN_PAN_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SAGP_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SAGP_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/sagp_pkg.sv */
package sagp_pkg;

    localparam logic [15:0] UNITY_Q15   = 16'd32768;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;
    localparam logic [7:0]  EV_RESET    = 8'd128;
    // ceil(2^33 / 255), exact divide by 255 for quotients of values below 2^25
    localparam logic [25:0] GAIN_RECIP  = 26'd33686019;
    // smallest product whose scaled gain reaches unity
    localparam logic [31:0] GAIN_SAT_X  = 32'd1069547520;

    typedef enum logic [1:0] {
        JOB_GLOBAL,
        JOB_SKIP,
        JOB_SPATIAL
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [32:0] ax;
        logic [32:0] ay;
        logic        dx_pos;
        logic [30:0] rin;
        logic [30:0] rout;
        logic [23:0] base;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SQRT,
        B_PREP,
        B_LEVEL,
        B_MULT,
        B_FRAC,
        B_DONE
    } back_state_t;

endpackage

/* design/sagp_front.sv */
module sagp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] ear_x,
    input  logic signed [31:0] ear_y,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    input  logic signed [31:0] inner_radius,
    input  logic signed [31:0] outer_radius,
    input  logic               spatial,
    input  logic [15:0]        source_volume,
    input  sagp_pkg::q_status_t q_status,
    output logic               push,
    output sagp_pkg::job_t     push_job
);
    import sagp_pkg::*;

    logic [7:0]         ev_reg;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               range_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= EV_RESET;
        end
        else if (cfg_valid)
        begin
            ev_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign push      = in_valid && !q_status.full;

    always_comb
    begin
        dx = {source_x[31], source_x} - {ear_x[31], ear_x};
        dy = {source_y[31], source_y} - {ear_y[31], ear_y};
        range_bad = outer_radius[31] || (outer_radius == 32'sd0) || inner_radius[31];

        push_job.ax     = dx[32] ? (~dx + 33'd1) : dx;
        push_job.ay     = dy[32] ? (~dy + 33'd1) : dy;
        push_job.dx_pos = !dx[32] && (dx != 33'sd0);
        push_job.rout   = outer_radius[30:0];
        // overlapping rings: inner ring counts as zero
        push_job.rin    = (inner_radius >= outer_radius) ? 31'd0 : inner_radius[30:0];
        push_job.base   = 24'(ev_reg) * 24'(source_volume);
        if (!spatial)
        begin
            push_job.kind = JOB_GLOBAL;
        end
        else if (range_bad)
        begin
            push_job.kind = JOB_SKIP;
        end
        else
        begin
            push_job.kind = JOB_SPATIAL;
        end
    end

endmodule

/* design/sagp_queue.sv */
module sagp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sagp_pkg::job_t      push_job,
    input  logic                pop,
    output sagp_pkg::job_t      pop_job,
    output sagp_pkg::q_status_t q_status
);
    import sagp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_job        = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

/* design/sagp_back.sv */
`include "spatial_audio_gain_pan_unit_defines.svh"

module sagp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sagp_pkg::q_status_t q_status,
    input  sagp_pkg::job_t      pop_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                skipped,
    output logic                muted,
    output logic [7:0]          distance_level,
    output logic [15:0]         gain,
    output logic [15:0]         left_gain,
    output logic [15:0]         right_gain
);
    import sagp_pkg::*;

    back_state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    job_t        job_reg;
    logic        mute_reg;
    logic [65:0] acc_reg;
    logic [32:0] mqx_reg, mqy_reg;
    logic [65:0] mcx_reg, mcy_reg;
    logic [35:0] rem_reg;
    logic [32:0] root_reg;
    logic [40:0] num_reg;
    logic [37:0] dsh_reg;
    logic [7:0]  lvl_reg;
    logic [31:0] gx_reg;
    logic [14:0] gq_reg;
    logic        gsat_reg;
    logic [45:0] pn_reg;
    logic [44:0] pd_reg;
    logic [14:0] pq_reg;
    logic        psat_reg;

    logic        out_valid_reg;
    logic        skipped_reg, muted_reg;
    logic [7:0]  level_reg;
    logic [15:0] gain_reg, left_reg, right_reg;

    logic        load;
    logic        last_sq, last_sqrt, last_level, last_frac;

    logic [65:0] sq_sum;
    logic [37:0] rem_sh, trial;
    logic        root_bit;
    logic [32:0] rin33, eff;
    logic [30:0] denom;
    logic [40:0] n_prep;
    logic        mute_prep;
    logic        lvl_bit, p_bit;
    logic [31:0] gx_mult;
    logic [50:0] g_prod;

    logic        res_skip, res_mute;
    logic [7:0]  res_level;
    logic [15:0] res_gain, res_left, res_right, pan_p;
    logic [16:0] glob_g;

    logic        mute_ok, skip_ok;

    assign last_sq    = (cnt_reg == 6'd32);
    assign last_sqrt  = (cnt_reg == 6'd32);
    assign last_level = (cnt_reg == 6'd7);
    assign last_frac  = (cnt_reg == 6'd14);

    // datapath step logic
    always_comb
    begin
        sq_sum = acc_reg + (mqx_reg[0] ? mcx_reg : 66'd0) + (mqy_reg[0] ? mcy_reg : 66'd0);

        rem_sh   = {rem_reg, acc_reg[65:64]};
        trial    = {3'd0, root_reg, 2'b01};
        root_bit = (rem_sh >= trial);

        rin33     = {2'd0, job_reg.rin};
        eff       = (root_reg < rin33) ? 33'd0 : root_reg - rin33;
        denom     = job_reg.rout - job_reg.rin;
        n_prep    = {eff, 8'd0} - {8'd0, eff};
        mute_prep = (n_prep >= {2'd0, denom, 8'd0});

        lvl_bit = (num_reg >= {3'd0, dsh_reg});
        gx_mult = 32'(job_reg.base) * 32'(LEVEL_MAX - lvl_reg);
        // divide by 128 * 255: drop 7 bits, then reciprocal multiply for 255
        g_prod  = 51'(gx_reg[31:7]) * 51'(GAIN_RECIP);
        p_bit   = (pn_reg >= {1'b0, pd_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (pop_job.kind == JOB_SPATIAL) ? B_SQ : B_DONE;
                end
            end
            B_SQ:    state_next = last_sq ? B_SQRT : B_SQ;
            B_SQRT:  state_next = last_sqrt ? B_PREP : B_SQRT;
            B_PREP:  state_next = mute_prep ? B_DONE : B_LEVEL;
            B_LEVEL: state_next = last_level ? B_MULT : B_LEVEL;
            B_MULT:  state_next = B_FRAC;
            B_FRAC:  state_next = last_frac ? B_DONE : B_FRAC;
            B_DONE:  state_next = load ? B_IDLE : B_DONE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop  = (state_reg == B_IDLE) && !q_status.empty;
        load = (state_reg == B_DONE) && (!out_valid_reg || out_ready);
    end

    // result assembly
    always_comb
    begin
        glob_g    = job_reg.base[23:7];
        pan_p     = psat_reg ? UNITY_Q15 : {1'b0, pq_reg};
        res_skip  = 1'b0;
        res_mute  = 1'b0;
        res_level = 8'd0;
        res_gain  = 16'd0;
        res_left  = 16'd0;
        res_right = 16'd0;
        case (job_reg.kind)
            JOB_GLOBAL:
            begin
                res_gain  = (glob_g > 17'(UNITY_Q15)) ? UNITY_Q15 : glob_g[15:0];
                res_left  = UNITY_Q15;
                res_right = UNITY_Q15;
            end
            JOB_SPATIAL:
            begin
                if (mute_reg)
                begin
                    res_mute  = 1'b1;
                    res_level = LEVEL_MAX;
                end
                else
                begin
                    res_level = lvl_reg;
                    res_gain  = gsat_reg ? UNITY_Q15 : {1'b0, gq_reg};
                    res_left  = job_reg.dx_pos ? UNITY_Q15 - pan_p : UNITY_Q15;
                    res_right = job_reg.dx_pos ? UNITY_Q15 : UNITY_Q15 - pan_p;
                end
            end
            default:
            begin
                res_skip = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 6'd0 : cnt_reg + 6'd1;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg  <= pop_job;
                mute_reg <= 1'b0;
                acc_reg  <= 66'd0;
                mqx_reg  <= pop_job.ax;
                mqy_reg  <= pop_job.ay;
                mcx_reg  <= {33'd0, pop_job.ax};
                mcy_reg  <= {33'd0, pop_job.ay};
                rem_reg  <= 36'd0;
                root_reg <= 33'd0;
            end
            B_SQ:
            begin
                acc_reg <= sq_sum;
                mqx_reg <= mqx_reg >> 1;
                mqy_reg <= mqy_reg >> 1;
                mcx_reg <= mcx_reg << 1;
                mcy_reg <= mcy_reg << 1;
            end
            B_SQRT:
            begin
                acc_reg  <= acc_reg << 2;
                rem_reg  <= root_bit ? 36'(rem_sh - trial) : rem_sh[35:0];
                root_reg <= {root_reg[31:0], root_bit};
            end
            B_PREP:
            begin
                mute_reg <= mute_prep;
                num_reg  <= n_prep;
                dsh_reg  <= {denom, 7'd0};
                lvl_reg  <= 8'd0;
            end
            B_LEVEL:
            begin
                if (lvl_bit)
                begin
                    num_reg <= num_reg - {3'd0, dsh_reg};
                end
                dsh_reg <= dsh_reg >> 1;
                lvl_reg <= {lvl_reg[6:0], lvl_bit};
            end
            B_MULT:
            begin
                gx_reg   <= gx_mult;
                gsat_reg <= (gx_mult >= GAIN_SAT_X);
                gq_reg   <= 15'd0;
                psat_reg <= (job_reg.ax >= {2'd0, job_reg.rout});
                pn_reg   <= {job_reg.ax[30:0], 15'd0};
                pd_reg   <= {job_reg.rout, 14'd0};
                pq_reg   <= 15'd0;
            end
            B_FRAC:
            begin
                gq_reg <= g_prod[47:33];
                if (p_bit)
                begin
                    pn_reg <= pn_reg - {1'b0, pd_reg};
                end
                pd_reg <= pd_reg >> 1;
                pq_reg <= {pq_reg[13:0], p_bit};
            end
            default:
            begin
            end
        endcase

        if (load)
        begin
            skipped_reg <= res_skip;
            muted_reg   <= res_mute;
            level_reg   <= res_level;
            gain_reg    <= res_gain;
            left_reg    <= res_left;
            right_reg   <= res_right;
        end
    end

    assign out_valid      = out_valid_reg;
    assign skipped        = skipped_reg;
    assign muted          = muted_reg;
    assign distance_level = level_reg;
    assign gain           = gain_reg;
    assign left_gain      = left_reg;
    assign right_gain     = right_reg;

    assign mute_ok = (gain_reg == 16'd0) && (left_reg == 16'd0) && (right_reg == 16'd0)
                     && (level_reg == LEVEL_MAX);
    assign skip_ok = !muted_reg && (gain_reg == 16'd0) && (level_reg == 8'd0);

    `SAGP_ASSERT_IMP(a_muted_silent, out_valid_reg && muted_reg, mute_ok, "muted beat not silent")
    `SAGP_ASSERT_IMP(a_skip_clean, out_valid_reg && skipped_reg, skip_ok, "skipped beat not clean")
    `SAGP_ASSERT_IMP(a_level_count, state_reg == B_LEVEL, cnt_reg < 6'd8, "level divide overran")
    `SAGP_ASSERT_NXT(a_load_done, load, (state_reg == B_IDLE) && out_valid_reg, "job not retired")

endmodule

/* design/spatial_audio_gain_pan_unit.sv */
// Distance attenuation and stereo pan, one result beat per source beat. A global
// source (spatial low) is popped from the queue and then handed off to the output
// register. A spatial source is popped, then runs a bit-serial square-and-sum of
// the offsets, a digit-by-digit square root, a prep step, the falloff-level
// divide, a multiply step and the pan divide with the gain taken by a reciprocal
// multiply alongside, and is then handed off to the output register. A source
// beyond the outer ring skips the level, gain and pan steps. A skipped source
// takes the same path as a global one. The front end takes a source beat every
// cycle while the job queue has room, so beats can arrive back to back while the
// back end works and while a result waits on out_ready. Coordinates and radii are
// signed Q24.8, gains Q1.15 with 32768 meaning unity. engine_volume resets to 128
// and the user must write it through the cfg port only while idle; the block
// itself does not enforce this.
module spatial_audio_gain_pan_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration: engine volume
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    // source beats
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] ear_x,
    input  logic signed [31:0] ear_y,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    input  logic signed [31:0] inner_radius,
    input  logic signed [31:0] outer_radius,
    input  logic               spatial,
    input  logic [15:0]        source_volume,
    // result beats
    output logic               out_valid,
    input  logic               out_ready,
    output logic               skipped,
    output logic               muted,
    output logic [7:0]         distance_level,
    output logic [15:0]        gain,
    output logic [15:0]        left_gain,
    output logic [15:0]        right_gain
);
    import sagp_pkg::*;

    // front to queue
    logic      push;
    job_t      push_job;
    // queue to back
    logic      pop;
    job_t      pop_job;
    q_status_t q_status;

    // classify the source, fold in engine volume, take offsets apart
    sagp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ear_x         (ear_x),
        .ear_y         (ear_y),
        .source_x      (source_x),
        .source_y      (source_y),
        .inner_radius  (inner_radius),
        .outer_radius  (outer_radius),
        .spatial       (spatial),
        .source_volume (source_volume),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    // short job queue decoupling the two ends
    sagp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    // iterative distance, level, gain and pan, with output register
    sagp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .pop_job        (pop_job),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .skipped        (skipped),
        .muted          (muted),
        .distance_level (distance_level),
        .gain           (gain),
        .left_gain      (left_gain),
        .right_gain     (right_gain)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    import sagp_pkg::*;

    // result beat as seen on the output ports
    typedef struct packed {
        logic        skipped;
        logic        muted;
        logic [7:0]  distance_level;
        logic [15:0] gain;
        logic [15:0] left_gain;
        logic [15:0] right_gain;
    } gain_pan_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [7:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] ear_x;
    logic signed [31:0] ear_y;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] inner_radius;
    logic signed [31:0] outer_radius;
    logic spatial;
    logic [15:0] source_volume;
    logic out_valid;
    logic out_ready;
    logic skipped;
    logic muted;
    logic [7:0] distance_level;
    logic [15:0] gain;
    logic [15:0] left_gain;
    logic [15:0] right_gain;

    spatial_audio_gain_pan_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ear_x          (ear_x),
        .ear_y          (ear_y),
        .source_x       (source_x),
        .source_y       (source_y),
        .inner_radius   (inner_radius),
        .outer_radius   (outer_radius),
        .spatial        (spatial),
        .source_volume  (source_volume),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .skipped        (skipped),
        .muted          (muted),
        .distance_level (distance_level),
        .gain           (gain),
        .left_gain      (left_gain),
        .right_gain     (right_gain)
    );

    // predictor copy of the volume register
    logic [7:0] master_volume;
    // results the block owes us, oldest first
    gain_pan_t  pending_mix[$];
    int         error_count;
    longint     cycle_count;
    // idling knobs, percent of cycles
    int         send_idle_pct;
    int         recv_stall_pct;
    // long receiver hold-off, counted down by its own process
    int         hold_cycles;

    localparam longint CYCLE_LIMIT = 4000000;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // floor of the square root of a 66-bit value, bit by bit
    function automatic logic [32:0] root_floor(input logic [65:0] v);
        logic [32:0] r;
        logic [65:0] t;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            t = {33'd0, r | (33'd1 << b)};
            if (t * t <= v)
                r = r | (33'd1 << b);
        end
        return r;
    endfunction

    // expected result for one source beat under the current volume
    function automatic gain_pan_t mix_predict(
        input logic signed [31:0] lx, input logic signed [31:0] ly,
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic signed [31:0] rin_in, input logic signed [31:0] rout_in,
        input logic sp, input logic [15:0] vol);
        gain_pan_t   r;
        logic [63:0] base;
        logic signed [33:0] dx, dy;
        logic [32:0] ax, ay;
        logic [65:0] sumsq;
        logic [63:0] d, rin, rout, eff, level, g, p;
        r = '0;
        base = 64'(master_volume) * 64'(vol);
        if (!sp)
        begin
            g = base / 128;
            r.gain = (g > 32768) ? 16'd32768 : g[15:0];
            r.left_gain = UNITY_Q15;
            r.right_gain = UNITY_Q15;
            return r;
        end
        if (rout_in <= 0 || rin_in < 0)
        begin
            r.skipped = 1'b1;
            return r;
        end
        rout = 64'(rout_in);
        rin = (rin_in >= rout_in) ? 64'd0 : 64'(rin_in);
        dx = 34'(sx) - 34'(lx);
        dy = 34'(sy) - 34'(ly);
        ax = dx < 0 ? 33'(-dx) : 33'(dx);
        ay = dy < 0 ? 33'(-dy) : 33'(dy);
        sumsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        d = 64'(root_floor(sumsq));
        eff = (d < rin) ? 64'd0 : d - rin;
        level = eff * 255 / (rout - rin);
        if (level > 255)
        begin
            r.muted = 1'b1;
            r.distance_level = LEVEL_MAX;
            return r;
        end
        r.distance_level = level[7:0];
        g = base * (255 - level) / 32640;
        r.gain = (g > 32768) ? 16'd32768 : g[15:0];
        p = 64'(ax) * 32768 / rout;
        if (p > 32768)
            p = 32768;
        if (dx > 0)
        begin
            r.left_gain = 16'(32768 - p);
            r.right_gain = UNITY_Q15;
        end
        else
        begin
            r.left_gain = UNITY_Q15;
            r.right_gain = 16'(32768 - p);
        end
        return r;
    endfunction

    // receiver: random stalls plus the long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    initial
    begin
        gain_pan_t got;
        gain_pan_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = {skipped, muted, distance_level, gain, left_gain, right_gain};
                if (pending_mix.size() == 0)
                begin
                    $display("%0t unexpected result beat %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = pending_mix.pop_front();
                    if (got.skipped !== want.skipped)
                    begin
                        $display("%0t skipped exp %0d got %0d", $time, want.skipped, got.skipped);
                        error_count++;
                    end
                    if (got.muted !== want.muted)
                    begin
                        $display("%0t muted exp %0d got %0d", $time, want.muted, got.muted);
                        error_count++;
                    end
                    if (got.distance_level !== want.distance_level)
                    begin
                        $display("%0t level exp %0d got %0d", $time,
                                 want.distance_level, got.distance_level);
                        error_count++;
                    end
                    if (got.gain !== want.gain)
                    begin
                        $display("%0t gain exp %0d got %0d", $time, want.gain, got.gain);
                        error_count++;
                    end
                    if (got.left_gain !== want.left_gain)
                    begin
                        $display("%0t left exp %0d got %0d", $time,
                                 want.left_gain, got.left_gain);
                        error_count++;
                    end
                    if (got.right_gain !== want.right_gain)
                    begin
                        $display("%0t right exp %0d got %0d", $time,
                                 want.right_gain, got.right_gain);
                        error_count++;
                    end
                end
            end
        end
    end

    // one source beat; prediction is queued at the accepting edge
    // valid stays up after the beat so a following beat can go back to back
    task automatic send_source(
        input logic signed [31:0] lx, input logic signed [31:0] ly,
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic signed [31:0] rin, input logic signed [31:0] rout,
        input logic sp, input logic [15:0] vol);
        // random gap before the beat
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        ear_x         <= lx;
        ear_y         <= ly;
        source_x      <= sx;
        source_y      <= sy;
        inner_radius  <= rin;
        outer_radius  <= rout;
        spatial       <= sp;
        source_volume <= vol;
        do
            @(posedge clk);
        while (!in_ready);
        pending_mix.push_back(mix_predict(lx, ly, sx, sy, rin, rout, sp, vol));
    endtask

    // stop sending, wait out every owed result, then the back end's tail
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // volume write while the block is idle
    task automatic write_volume(input logic [7:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        master_volume = v;
        cfg_valid <= 1'b0;
    endtask

    // random radius, mostly sensible with some skips and overlaps
    function automatic logic signed [31:0] pick_radius();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'sd0;
            2:       return -$signed(32'($urandom_range(1000)));
            3:       return 32'sh7fffffff;
            default: return $signed(32'($urandom_range(1, 1 << 20)));
        endcase
    endfunction

    // random coordinate near the listener or anywhere
    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] around);
        if ($urandom_range(3) == 0)
            return $urandom;
        return around + $signed(32'($urandom_range(0, 1 << 21))) - 32'sd1048576;
    endfunction

    task automatic send_random_source();
        logic signed [31:0] lx, ly, ro, ri;
        logic [15:0] v;
        lx = $urandom_range(4) == 0 ? $urandom : $signed(32'($urandom_range(0, 1 << 16)));
        ly = $urandom_range(4) == 0 ? $urandom : $signed(32'($urandom_range(0, 1 << 16)));
        ro = pick_radius();
        ri = $urandom_range(3) == 0 ? pick_radius() : $signed(32'($urandom_range(0, 1 << 18)));
        v  = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
        send_source(lx, ly, pick_coord(lx), pick_coord(ly), ri, ro,
                    $urandom_range(4) != 0, v);
    endtask

    task automatic test_directed();
        // global: volume extremes
        send_source(0, 0, 0, 0, 0, 0, 1'b0, 16'd32768);
        send_source(0, 0, 0, 0, 0, 0, 1'b0, 16'd0);
        send_source(32'sh7fffffff, 32'sh80000000, 5, 5, -1, -1, 1'b0, 16'hffff);
        // invalid ranges
        send_source(0, 0, 100, 0, 0, 0, 1'b1, 16'd32768);
        send_source(0, 0, 100, 0, -1, 256, 1'b1, 16'd32768);
        send_source(0, 0, 100, 0, 0, 32'sh80000000, 1'b1, 16'd32768);
        // inside inner ring, on center, left and right
        send_source(0, 0, 0, 0, 2560, 5120, 1'b1, 16'd32768);
        send_source(0, 0, 1000, 0, 2560, 5120, 1'b1, 16'd32768);
        send_source(0, 0, -1000, 0, 2560, 5120, 1'b1, 16'd32768);
        // between rings, exactly at the outer edge, beyond it
        send_source(0, 0, 3840, 0, 2560, 5120, 1'b1, 16'd20000);
        send_source(0, 0, 0, 5120, 2560, 5120, 1'b1, 16'd32768);
        send_source(0, 0, 5200, 0, 2560, 5120, 1'b1, 16'd32768);
        // overlapping rings
        send_source(0, 0, 300, 400, 5120, 1000, 1'b1, 16'd32768);
        send_source(0, 0, 300, 400, 1000, 1000, 1'b1, 16'd32768);
        // widest offsets and radii
        send_source(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                    0, 32'sh7fffffff, 1'b1, 16'hffff);
        send_source(32'sh7fffffff, 0, 32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff,
                    1'b1, 16'd32768);
        send_source(0, 0, 1, 0, 0, 1, 1'b1, 16'hffff);
        send_source(0, 0, 32'sh7fffffff, 0, 0, 32'sh7fffffff, 1'b1, 16'd32768);
        drain_results();
    endtask

    task automatic test_idling(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_source();
        drain_results();
    endtask

    // receiver holds off while the sender keeps pushing, then a quiet pause
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 800;
        repeat (12) send_random_source();
        drain_results();
        repeat (10) send_random_source();
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        ear_x         = '0;
        ear_y         = '0;
        source_x      = '0;
        source_y      = '0;
        inner_radius  = '0;
        outer_radius  = '0;
        spatial       = 1'b0;
        source_volume = '0;
        master_volume = EV_RESET;
        error_count   = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset volume first, then the extremes
        test_directed();
        write_volume(8'd0);
        test_directed();
        write_volume(8'd255);
        test_directed();
        write_volume(8'd128);
        test_idling(0, 0, 400);
        write_volume(8'($urandom_range(0, 128)));
        test_idling(88, 0, 350);
        write_volume(8'($urandom));
        test_idling(0, 88, 350);
        write_volume(8'd1);
        test_idling(33, 33, 350);
        write_volume(8'd128);
        test_backpressure();
        test_idling(33, 33, 150);

        drain_results();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
